### rtl/sbda_pkg.sv
package sbda_pkg;

   // width of the converted value; bit VALUE_BITS-1 is the sign
   localparam int VALUE_BITS = 32;

   // decimal digits needed for a magnitude of up to 2^VALUE_BITS - 1
   localparam int DIGITS     = (VALUE_BITS * 1233) / 4096 + 1;
   localparam int BCD_BITS   = DIGITS * 4;
   localparam int IDX_BITS   = $clog2(DIGITS);
   localparam int CNT_BITS   = $clog2(VALUE_BITS);

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);

   // ASCII codes
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // one classified request: sign and magnitude
   typedef struct packed {
      logic                  negative;
      logic [VALUE_BITS-1:0] magnitude;
   } entry_type;

endpackage

### rtl/sbda_queue.sv
module sbda_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sbda_pkg::entry_type push_data,
   output logic                full,
   input  logic                pop,
   output sbda_pkg::entry_type pop_data,
   output logic                empty
);

   sbda_pkg::entry_type                 entry_ff [sbda_pkg::QUEUE_DEPTH];
   logic [sbda_pkg::PTR_BITS-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [sbda_pkg::PTR_BITS-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [sbda_pkg::PTR_BITS:0]         count_ff, count_in;
   logic                                do_push, do_pop;

   assign full     = (count_ff == (sbda_pkg::PTR_BITS+1)'(sbda_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/sbda_front.sv
module sbda_front (
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [31:0]         req_tdata,
   input  logic                queue_full,
   output logic                push,
   output sbda_pkg::entry_type push_data
);

   logic [sbda_pkg::VALUE_BITS-1:0] raw;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   // sign and magnitude; the most negative value negates to 2^(VALUE_BITS-1)
   assign raw                 = req_tdata[sbda_pkg::VALUE_BITS-1:0];
   assign push_data.negative  = raw[sbda_pkg::VALUE_BITS-1];
   assign push_data.magnitude = raw[sbda_pkg::VALUE_BITS-1] ? (~raw + 1'b1) : raw;

endmodule

### rtl/sbda_back.sv
module sbda_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   input  sbda_pkg::entry_type pop_data,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SKIP = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]                       state_ff, state_in;
   logic [sbda_pkg::VALUE_BITS-1:0]  mag_ff, mag_in;
   logic [sbda_pkg::BCD_BITS-1:0]    bcd_ff, bcd_in;
   logic [sbda_pkg::CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [sbda_pkg::IDX_BITS-1:0]    idx_ff, idx_in;
   logic                             neg_ff, neg_in;
   logic                             sign_ff, sign_in;
   logic                             out_valid_ff, out_valid_in;
   logic [7:0]                       out_data_ff, out_data_in;
   logic                             out_last_ff, out_last_in;
   logic [sbda_pkg::BCD_BITS-1:0]    bcd_adj;
   logic [3:0]                       digit;
   logic                             slot_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign slot_free  = !out_valid_ff || rsp_tready;
   assign pop        = (state_ff == ST_IDLE) && !queue_empty;
   assign digit      = bcd_ff[idx_ff*4 +: 4];

   // add 3 to every BCD digit of 5 or more before the shift
   always_comb begin
      for (int d = 0; d < sbda_pkg::DIGITS; d++) begin
         if (bcd_ff[d*4 +: 4] >= 4'd5) begin
            bcd_adj[d*4 +: 4] = bcd_ff[d*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[d*4 +: 4] = bcd_ff[d*4 +: 4];
         end
      end
   end

   // sequencer: load, shift-and-adjust, skip leading zeros, emit characters
   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      neg_in       = neg_ff;
      sign_in      = sign_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               mag_in   = pop_data.magnitude;
               neg_in   = pop_data.negative;
               bcd_in   = '0;
               cnt_in   = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in = {bcd_adj[sbda_pkg::BCD_BITS-2:0], mag_ff[sbda_pkg::VALUE_BITS-1]};
            mag_in = {mag_ff[sbda_pkg::VALUE_BITS-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == sbda_pkg::CNT_BITS'(sbda_pkg::VALUE_BITS - 1)) begin
               idx_in   = sbda_pkg::IDX_BITS'(sbda_pkg::DIGITS - 1);
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (digit == 4'd0 && idx_ff != '0) begin
               idx_in = idx_ff - 1'b1;
            end else begin
               sign_in  = neg_ff;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               if (sign_ff) begin
                  out_data_in = sbda_pkg::CHAR_MINUS;
                  out_last_in = 1'b0;
                  sign_in     = 1'b0;
               end else begin
                  out_data_in = sbda_pkg::CHAR_ZERO + {4'd0, digit};
                  out_last_in = (idx_ff == '0);
                  if (idx_ff == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     idx_in = idx_ff - 1'b1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      neg_ff      <= neg_in;
      sign_ff     <= sign_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

endmodule

### rtl/signed_binary_to_decimal_ascii.sv
// Channel   Direction  Ports            Payload
// request   in         req_tvalid/ready req_tdata[31:0] = value (signed)
// response  out        rsp_tvalid/ready rsp_tdata[7:0] = char_code, rsp_tlast = last
//
// In the back end one value is taken from the queue, goes through 32 shift-and-adjust
// steps of the double-dabble loop and a leading zero scan, and is then emitted one
// character per cycle, minus sign first, while the response is not stalled.
// The front end takes requests into a two-entry queue while the back end works.
// Reset is synchronous and clears the queue, the sequencer and the response valid.
// A stalled response holds the back end; the queue keeps taking requests until full.
module signed_binary_to_decimal_ascii (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] char_code
   output logic        rsp_tlast
);

   sbda_pkg::entry_type push_data, pop_data;
   logic                push, pop, queue_full, queue_empty;

   // classify incoming requests
   sbda_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   // decouple front and back
   sbda_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   // convert and emit characters
   sbda_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .pop_data    (pop_data),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

### dv/signed_binary_to_decimal_ascii_check.sv
// Watches both streams, predicts the decimal text of every accepted request
// and compares each response character against the oldest one still waiting.
module signed_binary_to_decimal_ascii_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [7:0] char_code
   input  logic        rsp_tlast,
   output int          error_count,
   output int          pending_chars,
   output int          chars_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DECIMAL_BASE = 10;
   localparam int DIGIT_SLOTS  = 24;

   typedef struct {
      logic [7:0] char_code;
      logic       last;
   } text_char_type;

   // characters still owed by the block, oldest first
   text_char_type expected_text[$];

   // append the decimal text of one value, sign first, no leading zeros
   function automatic void spell_decimal(input logic [31:0] value);
      logic [63:0]   mask;
      logic [63:0]   raw;
      logic [63:0]   mag;
      logic [3:0]    digit_stack[DIGIT_SLOTS];
      logic          negative;
      int            ndig;
      text_char_type ch;
      mask     = {64{1'b1}} >> (64 - sbda_pkg::VALUE_BITS);
      raw      = {32'd0, value} & mask;
      negative = raw[sbda_pkg::VALUE_BITS-1];
      // most negative value comes out as 2^(VALUE_BITS-1), no overflow
      mag      = negative ? ((~raw + 64'd1) & mask) : raw;
      ndig     = 0;
      do begin
         digit_stack[ndig] = 4'(mag % DECIMAL_BASE);
         mag = mag / DECIMAL_BASE;
         ndig++;
      end while (mag != 0 && ndig < DIGIT_SLOTS);
      if (negative) begin
         ch.char_code = sbda_pkg::CHAR_MINUS;
         ch.last      = 1'b0;
         expected_text.push_back(ch);
      end
      for (int k = ndig - 1; k >= 0; k--) begin
         ch.char_code = sbda_pkg::CHAR_ZERO + 8'(digit_stack[k]);
         ch.last      = (k == 0);
         expected_text.push_back(ch);
      end
   endfunction

   initial begin
      error_count   = 0;
      pending_chars = 0;
      chars_checked = 0;
   end

   // compare responses first, then queue up the text of a new request
   always @(posedge clock) begin
      text_char_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_text.size() == 0) begin
               $error("unexpected response: char_code=%h last=%b", rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               want = expected_text.pop_front();
               chars_checked++;
               if (rsp_tdata !== want.char_code) begin
                  $error("char_code: expected %h actual %h", want.char_code, rsp_tdata);
                  error_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %b actual %b", want.last, rsp_tlast);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            spell_decimal(req_tdata);
         pending_chars = expected_text.size();
      end
   end

endmodule

### dv/signed_binary_to_decimal_ascii_test.sv
module signed_binary_to_decimal_ascii_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 64;
   localparam int CHUNKS        = 6;
   localparam int CHUNK_VALUES  = 32;

   typedef enum logic [1:0] {DRAIN_OPEN, DRAIN_RANDOM, DRAIN_PATTERN} drain_mode_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] value
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [7:0] char_code
   logic        rsp_tlast;

   int error_count;
   int pending_chars;
   int chars_checked;

   drain_mode_type drain_mode = DRAIN_OPEN;
   logic [15:0] drain_pattern = 16'hFFFF;
   int          pattern_age = 0;
   int          cycle_count = 0;
   int          sent_count = 0;
   int          negative_count = 0;

   // edge values, digit-count boundaries and the most negative value
   int directed_values[$] = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345,
                              999999999, 1000000000, -1000000000, 1234567890,
                              -1234567890, 32'h7FFFFFFF, -32'sh7FFFFFFF, 32'h80000000,
                              32'h55555555, 32'hAAAAAAAA};

   signed_binary_to_decimal_ascii dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   signed_binary_to_decimal_ascii_check check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .error_count   (error_count),
      .pending_chars (pending_chars),
      .chars_checked (chars_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("signed_binary_to_decimal_ascii regression: fail");
         $finish;
      end
   end

   // response side backpressure: open, coin flips, or a rotating stall pattern
   always @(negedge clock) begin
      case (drain_mode)
         DRAIN_OPEN: begin
            rsp_tready <= 1'b1;
         end
         DRAIN_RANDOM: begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_tready    <= drain_pattern[0];
            pattern_age   <= (pattern_age == 15) ? 0 : pattern_age + 1;
            drain_pattern <= (pattern_age == 15) ? 16'($urandom())
                                                 : {drain_pattern[0], drain_pattern[15:1]};
         end
      endcase
   end

   // random value, weighted toward digit-count and sign boundaries
   function automatic logic [31:0] pick_value();
      longint unsigned span;
      logic [31:0]     v;
      int              digits;
      int              kind;
      kind = $urandom_range(0, 4);
      case (kind)
         0: begin
            v = $urandom();
         end
         1: begin
            v = $urandom_range(0, 99);
         end
         2: begin
            digits = $urandom_range(1, 10);
            span = 1;
            repeat (digits) span = span * 10;
            if (digits == 10)
               v = 32'd1000000000 + $urandom_range(0, 1147483647);
            else
               v = 32'(span / 10 + longint'($urandom()) % (span - span / 10));
         end
         3: begin
            v = $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 15)
                                     : 32'h80000000 + $urandom_range(0, 15);
         end
         default: begin
            span = 1;
            repeat ($urandom_range(0, 9)) span = span * 10;
            v = 32'(span) + $urandom_range(0, 2) - 1;
         end
      endcase
      if (kind != 0 && kind != 3 && $urandom_range(0, 1))
         v = -v;
      return v;
   endfunction

   // one request; returns at the falling edge after acceptance with valid still high
   task automatic send_value(input logic [31:0] value);
      req_tdata  <= value;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
      if (value[31]) negative_count++;
      @(negedge clock);
   endtask

   // requests in bursts with random gaps, or back to back
   task automatic drive_values(input logic [31:0] values[$], input bit bursty);
      int burst_left;
      burst_left = $urandom_range(1, 8);
      foreach (values[i]) begin
         send_value(values[i]);
         burst_left--;
         if (bursty && burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            burst_left = $urandom_range(1, 8);
         end
      end
      req_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [31:0] batch[$];
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed pass
      batch = {};
      foreach (directed_values[i]) batch.push_back(32'(directed_values[i]));
      drive_values(batch, 1'b1);

      // random pass, changing backpressure and burst style per chunk
      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
         drain_mode = drain_mode_type'(chunk % 3);
         batch = {};
         repeat (CHUNK_VALUES) batch.push_back(pick_value());
         drive_values(batch, !(chunk == 1 || chunk == 3));
      end

      // drain and let the block settle
      drain_mode = DRAIN_OPEN;
      while (pending_chars != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Converted %0d values (%0d negative) and checked %0d characters",
               sent_count, negative_count, chars_checked);
      $display("under open, random and patterned response stalls with bursty requests");
      if (error_count == 0 && pending_chars == 0)
         $display("signed_binary_to_decimal_ascii regression: pass");
      else
         $display("signed_binary_to_decimal_ascii regression: fail");
      $finish;
   end

endmodule
